// ===== rtl/core/swalk_pkg.sv =====
// ----------------------------------------------------------------------------
// swalk_pkg: shared types and codes for the self-avoiding walk step block
// Direction codes in ascending node order, event codes, pick result struct.
// ----------------------------------------------------------------------------
package swalk_pkg;

  localparam int DEF_MAX_SIDE = 64;
  localparam int SIDE_RESET   = 10;
  localparam logic [15:0] TRY_MAX = 16'hFFFF;

  // neighbour directions, in ascending node index order
  localparam logic [1:0] DIR_UP    = 2'd0;
  localparam logic [1:0] DIR_LEFT  = 2'd1;
  localparam logic [1:0] DIR_RIGHT = 2'd2;
  localparam logic [1:0] DIR_DOWN  = 2'd3;

  // result event codes
  localparam logic [1:0] EV_MOVED    = 2'd0;
  localparam logic [1:0] EV_STUCK    = 2'd1;
  localparam logic [1:0] EV_COMPLETE = 2'd2;

  typedef struct packed {
    logic       found;
    logic [1:0] dir;
  } pick_t;

endpackage

// ===== rtl/core/swalk_pick.sv =====
// ----------------------------------------------------------------------------
// swalk_pick: free neighbour selection
// Counts free neighbours and picks entry rnd mod count among them.
// ----------------------------------------------------------------------------
module swalk_pick
  import swalk_pkg::*;
(
  input  logic [3:0]  free,
  input  logic [15:0] rnd,
  output pick_t       pick
);

  // 4^k = 1 mod 3: fold 2-bit digits
  function automatic logic [1:0] mod3_16(input logic [15:0] v);
    logic [4:0] s0;
    logic [3:0] s1;
    logic [2:0] s2;
    logic [1:0] s3;
    s0 = 5'd0;
    for (int i = 0; i < 8; i++) begin
      s0 = s0 + {3'd0, v[2*i +: 2]};
    end
    s1 = {1'b0, s0[4:2]} + {2'd0, s0[1:0]};
    s2 = {1'b0, s1[3:2]} + {1'b0, s1[1:0]};
    s3 = {1'b0, s2[2]} + s2[1:0];
    return (s3 == 2'd3) ? 2'd0 : s3;
  endfunction

  logic [2:0] n;
  logic [1:0] k;
  logic [1:0] seen;

  always_comb begin
    n = 3'd0;
    for (int i = 0; i < 4; i++) begin
      n = n + {2'd0, free[i]};
    end
    case (n)
      3'd2:    k = {1'b0, rnd[0]};
      3'd3:    k = mod3_16(rnd);
      3'd4:    k = rnd[1:0];
      default: k = 2'd0;
    endcase
  end

  always_comb begin
    pick.found = (n != 3'd0);
    pick.dir   = DIR_UP;
    seen       = 2'd0;
    for (int i = 0; i < 4; i++) begin
      if (free[i]) begin
        if (seen == k) pick.dir = 2'(i);
        seen = seen + 2'd1;
      end
    end
  end

endmodule

// ===== rtl/core/self_avoiding_walk_step.sv =====
// ----------------------------------------------------------------------------
// self_avoiding_walk_step: random self-avoiding walk on a square grid
// A request is accepted only in ST_IDLE; ST_RD reads the visited map for
//   the four neighbours through the single read port, ST_PICK picks and
//   updates, held while the output stalls. No new request until then.
// Walk end or grid_side write: clearing pass over all grid_side^2 nodes,
//   no request taken meanwhile. Reset (sync, high) starts a clearing pass.
// ----------------------------------------------------------------------------
module self_avoiding_walk_step
  import swalk_pkg::*;
#(
  parameter int MAX_SIDE = DEF_MAX_SIDE
)
(
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_write,
  input  logic [6:0]  cfg_data,
  // request channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] random_value,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  event_kind,
  output logic [5:0]  node_row,
  output logic [5:0]  node_col,
  output logic [12:0] nodes_visited,
  output logic [15:0] walk_tries
);

  localparam int RB = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;  // row/col bits
  localparam int SB = $clog2(MAX_SIDE + 1);                   // side bits
  localparam int CB = $clog2(MAX_SIDE * MAX_SIDE + 1);        // count bits
  localparam int AW = 2 * RB;                                 // map address
  localparam int SIDE_INIT = (SIDE_RESET > MAX_SIDE) ? MAX_SIDE : SIDE_RESET;

  localparam logic [1:0] ST_CLR  = 2'd0;
  localparam logic [1:0] ST_IDLE = 2'd1;
  localparam logic [1:0] ST_RD   = 2'd2;
  localparam logic [1:0] ST_PICK = 2'd3;

  logic [1:0]    state;
  logic [SB-1:0] side;
  logic [CB-1:0] side_sq;
  logic [RB-1:0] cur_row, cur_col;
  logic [CB-1:0] visited_count;
  logic [15:0]   try_count;
  logic [15:0]   rnd;
  logic [2:0]    ph;       // read phase: issue 0..3, last data at 4
  logic [3:0]    free;
  logic [RB-1:0] clr_row, clr_col;

  // Visited map, addressed {row, col}. One write port, one read port, read
  // data registered. Read data is used only in ST_RD, writes happen only in ST_CLR
  // and ST_PICK, so the sequencer itself keeps accesses apart.
  logic          map [0:(1 << AW) - 1];
  logic          map_we;
  logic [AW-1:0] map_waddr;
  logic          map_wdata;
  logic [AW-1:0] map_raddr;
  logic          map_rdata;

  always_ff @(posedge clk) begin
    if (map_we) map[map_waddr] <= map_wdata;
    map_rdata <= map[map_raddr];
  end

  // neighbour in-bounds flags, current node always inside the grid
  logic [3:0]    inb;
  logic [SB-1:0] side_m1;
  assign side_m1 = side - SB'(1);
  assign inb[DIR_UP]    = (cur_row != '0);
  assign inb[DIR_LEFT]  = (cur_col != '0);
  assign inb[DIR_RIGHT] = (SB'(cur_col) != side_m1);
  assign inb[DIR_DOWN]  = (SB'(cur_row) != side_m1);

  function automatic logic [AW-1:0] nb_addr(input logic [1:0] d,
                                             input logic [RB-1:0] r,
                                             input logic [RB-1:0] c);
    logic [AW-1:0] a;
    case (d)
      DIR_UP:    a = {r - RB'(1), c};
      DIR_LEFT:  a = {r, c - RB'(1)};
      DIR_RIGHT: a = {r, c + RB'(1)};
      default:   a = {r + RB'(1), c};
    endcase
    return a;
  endfunction

  assign map_raddr = nb_addr(ph[1:0], cur_row, cur_col);

  // pick among free neighbours
  pick_t pk;
  swalk_pick u_pick (
    .free (free),
    .rnd  (rnd),
    .pick (pk)
  );

  logic [RB-1:0] new_row, new_col;
  always_comb begin
    new_row = cur_row;
    new_col = cur_col;
    case (pk.dir)
      DIR_UP:    new_row = cur_row - RB'(1);
      DIR_LEFT:  new_col = cur_col - RB'(1);
      DIR_RIGHT: new_col = cur_col + RB'(1);
      default:   new_row = cur_row + RB'(1);
    endcase
  end

  logic out_free;
  logic do_pick;
  logic complete;
  assign out_free = !out_valid || !out_stall;
  assign do_pick  = (state == ST_PICK) && out_free;
  assign complete = (visited_count == side_sq);
  assign in_stall = (state != ST_IDLE);

  logic clr_col_last, clr_row_last;
  assign clr_col_last = (SB'(clr_col) == side_m1);
  assign clr_row_last = (SB'(clr_row) == side_m1);

  always_comb begin
    map_we    = 1'b0;
    map_waddr = {clr_row, clr_col};
    map_wdata = (clr_row == '0) && (clr_col == '0);  // node 0 stays visited
    if (state == ST_CLR) begin
      map_we = 1'b1;
    end else if (do_pick && pk.found) begin
      map_we    = 1'b1;
      map_waddr = {new_row, new_col};
      map_wdata = 1'b1;
    end
  end

  // grid area for the completeness test
  logic [2*SB-1:0] sq_full;
  assign sq_full = {{SB{1'b0}}, side} * {{SB{1'b0}}, side};

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_CLR;
      side          <= SB'(SIDE_INIT);
      side_sq       <= CB'(SIDE_INIT * SIDE_INIT);
      cur_row       <= '0;
      cur_col       <= '0;
      visited_count <= CB'(1);
      try_count     <= 16'd1;
      clr_row       <= '0;
      clr_col       <= '0;
      ph            <= 3'd0;
      out_valid     <= 1'b0;
    end else begin
      side_sq <= CB'(sq_full);
      // result taken and no new one issued this cycle
      if (out_valid && !out_stall && !(do_pick && !cfg_write)) out_valid <= 1'b0;

      if (cfg_write) begin
        // side write abandons the walk, tries kept
        if (cfg_data < 7'd2) side <= SB'(2);
        else if (int'(cfg_data) > MAX_SIDE) side <= SB'(MAX_SIDE);
        else side <= SB'(cfg_data);
        cur_row       <= '0;
        cur_col       <= '0;
        visited_count <= CB'(1);
        clr_row       <= '0;
        clr_col       <= '0;
        state         <= ST_CLR;
      end else begin
        case (state)
          ST_CLR: begin
            if (clr_col_last) begin
              clr_col <= '0;
              if (clr_row_last) begin
                clr_row <= '0;
                state   <= ST_IDLE;
              end else begin
                clr_row <= clr_row + RB'(1);
              end
            end else begin
              clr_col <= clr_col + RB'(1);
            end
          end
          ST_IDLE: begin
            if (in_valid) begin
              rnd   <= random_value;
              ph    <= 3'd0;
              state <= ST_RD;
            end
          end
          ST_RD: begin
            // data for the read issued last cycle
            if (ph != 3'd0) begin
              free[ph[1:0] - 2'd1] <= inb[ph[1:0] - 2'd1] & ~map_rdata;
            end
            ph <= ph + 3'd1;
            if (ph == 3'd4) state <= ST_PICK;
          end
          ST_PICK: begin
            if (out_free) begin
              out_valid  <= 1'b1;
              walk_tries <= try_count;
              if (pk.found) begin
                event_kind    <= EV_MOVED;
                node_row      <= 6'(new_row);
                node_col      <= 6'(new_col);
                nodes_visited <= 13'(visited_count + CB'(1));
                cur_row       <= new_row;
                cur_col       <= new_col;
                visited_count <= visited_count + CB'(1);
                state         <= ST_IDLE;
              end else begin
                // walk end: report, bump tries (reset to 1 on a complete walk), restart with a clearing pass
                event_kind    <= complete ? EV_COMPLETE : EV_STUCK;
                node_row      <= 6'(cur_row);
                node_col      <= 6'(cur_col);
                nodes_visited <= 13'(visited_count);
                if (complete) try_count <= 16'd1;
                else if (try_count != TRY_MAX) try_count <= try_count + 16'd1;
                cur_row       <= '0;
                cur_col       <= '0;
                visited_count <= CB'(1);
                clr_row       <= '0;
                clr_col       <= '0;
                state         <= ST_CLR;
              end
            end
          end
          default: state <= ST_CLR;
        endcase
      end
    end
  end

  // no request taken during a clearing pass
  a_clr_stall: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLR) |-> in_stall)
    else $error("request accepted during map clear");

  // chosen neighbour must be one that was seen free
  a_pick_free: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PICK && pk.found) |-> free[pk.dir])
    else $error("picked a visited or off-grid neighbour");

  // position stays on the grid
  a_pos_in_grid: assert property (@(posedge clk) disable iff (rst)
    (state != ST_CLR) |-> (SB'(cur_row) < side && SB'(cur_col) < side))
    else $error("current node off the grid");

  // a walk end (stuck or complete) is followed by a clearing pass
  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    (do_pick && !pk.found) |=> (state == ST_CLR && cur_row == '0 && cur_col == '0))
    else $error("walk end did not restart");

endmodule
